// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and disabled
// while the asynchronous reset is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/sal_pkg.sv =====
// ---------------------------------------------------------------------------
// sal_pkg
// Shared widths, register indexes, reset values and types of the sensor
// average and calibration block.
// ---------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

	localparam int LEVEL_W    = 12;  // converter level registers
	localparam int TEMP_CFG_W = 10;  // temperature registers
	localparam int TEMP_W     = 11;  // temperature result
	localparam int SPAN_W     = 10;  // magnitude of temp_high - temp_low
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_AD_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AD_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 3'd3;

	localparam logic [LEVEL_W-1:0]           AD_LOW_RST    = 12'd1061;
	localparam logic [LEVEL_W-1:0]           AD_HIGH_RST   = 12'd2049;
	localparam logic signed [TEMP_CFG_W-1:0] TEMP_LOW_RST  = -10'sd10;
	localparam logic signed [TEMP_CFG_W-1:0] TEMP_HIGH_RST = 10'sd140;

	localparam int TEMP_MAX = 1023;
	localparam int TEMP_MIN = -1024;

	// status of a serial divider
	typedef struct packed {
		logic busy;
		logic last;  // final iteration in progress
	} sdiv_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sensor_average_linear_calibrate.sv =====
// ---------------------------------------------------------------------------
// sensor_average_linear_calibrate
// Moving average of converter samples over a ring of DEPTH entries, with a
// clamped linear mapping of the mean to a temperature.
//
//   channel   signals                                   direction
//   sample    sample_valid, sample_ready, sample        in
//   result    result_valid, result_ready,
//             average_level, temperature                out
//   config    cfg_we, cfg_index, cfg_data               in
//
// Each word runs the bit-serial divider twice before the next is accepted:
// once for the mean and once for the calibration slope term.
// The offset term runs on a second divider in parallel with the mean.
// A finished result waits in the output register; the next sample is taken
// meanwhile, and the block only stalls at its end if that register is full.
// No clearing pass after reset: ring entries are only used once written.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sensor_average_linear_calibrate #(
	parameter int DEPTH = 10,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  sample_valid,
	output logic                                       sample_ready,
	input  wire logic [SAMPLE_BITS-1:0]                sample,
	output logic                                       result_valid,
	input  wire logic                                  result_ready,
	output logic [SAMPLE_BITS-1:0]                     average_level,
	output logic signed [sal_pkg::TEMP_W-1:0]          temperature,
	input  wire logic                                  cfg_we,
	input  wire logic [sal_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [sal_pkg::CFG_DATA_W-1:0]        cfg_data
);

	import sal_pkg::*;

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(DEPTH);
	localparam int DIVA_N = SAMPLE_BITS + SPAN_W;
	localparam int DIVB_N = LEVEL_W + SPAN_W;
	localparam int CMP_W  = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
	localparam int T_W    = CMP_W + SPAN_W + 2;

	localparam logic signed [T_W-1:0] T_MAX = T_W'(TEMP_MAX);
	localparam logic signed [T_W-1:0] T_MIN = T_W'(TEMP_MIN);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DIV1,
		S_MUL,
		S_DIV2,
		S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [LEVEL_W-1:0]           ad_low_q;
	logic [LEVEL_W-1:0]           ad_high_q;
	logic signed [TEMP_CFG_W-1:0] temp_low_q;
	logic signed [TEMP_CFG_W-1:0] temp_high_q;

	// ring state
	logic [PTR_W-1:0]       wptr_q;
	logic                   warm_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] mean_q;

	logic                   result_valid_q;
	logic [SAMPLE_BITS-1:0] average_q;
	logic signed [TEMP_W-1:0] temp_q;

	logic                   accept;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       new_sum;
	logic                   wrap;
	logic [CNT_W-1:0]       cnt_next;

	logic signed [TEMP_W-1:0] span_t;
	logic [TEMP_W-1:0]        span_abs11;
	logic [SPAN_W-1:0]        span_abs;
	logic                     span_neg;
	logic [LEVEL_W-1:0]       span_ad;

	logic               diva_start;
	logic [DIVA_N-1:0]  diva_dividend;
	logic [LEVEL_W-1:0] diva_divisor;
	logic [DIVA_N-1:0]  diva_quo;
	sdiv_stat_t         diva_stat;
	logic               divb_start;
	logic [DIVB_N-1:0]  divb_dividend;
	logic [DIVB_N-1:0]  divb_quo;
	sdiv_stat_t         divb_stat;

	logic [T_W-1:0]           mag1;
	logic [T_W-1:0]           mag2;
	logic signed [T_W-1:0]    term1;
	logic signed [T_W-1:0]    term2;
	logic signed [T_W-1:0]    t_lin;
	logic signed [TEMP_W-1:0] t_sat;
	logic signed [TEMP_W-1:0] t_final;
	logic                     out_free;
	logic                     fin_go;

	// ---------------- configuration registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ad_low_q    <= AD_LOW_RST;
			ad_high_q   <= AD_HIGH_RST;
			temp_low_q  <= TEMP_LOW_RST;
			temp_high_q <= TEMP_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AD_LOW:    ad_low_q    <= cfg_data[LEVEL_W-1:0];
				REG_AD_HIGH:   ad_high_q   <= cfg_data[LEVEL_W-1:0];
				REG_TEMP_LOW:  temp_low_q  <= signed'(cfg_data[TEMP_CFG_W-1:0]);
				REG_TEMP_HIGH: temp_high_q <= signed'(cfg_data[TEMP_CFG_W-1:0]);
				default: ;
			endcase
		end
	end

	// ---------------- ring and running sum ----------------
	assign sample_ready = (state_q == S_IDLE);
	assign accept       = sample_valid && sample_ready;

	sal_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_READ),
		.waddr (wptr_q),
		.wdata (sample_q),
		.re    (accept),
		.raddr (wptr_q),
		.rdata (old_sample)
	);

	// oldest entry leaves the sum only once the ring has filled
	assign new_sum = sum_q - (warm_q ? SUM_W'(0) : SUM_W'(old_sample)) + SUM_W'(sample_q);
	assign wrap    = (wptr_q == PTR_W'(DEPTH - 1));
	assign cnt_next = (wrap || !warm_q) ? CNT_W'(DEPTH) : CNT_W'(wptr_q) + CNT_W'(1);

	// ---------------- calibration spans ----------------
	assign span_t     = TEMP_W'(temp_high_q) - TEMP_W'(temp_low_q);
	assign span_neg   = span_t[TEMP_W-1];
	assign span_abs11 = span_neg ? -span_t : span_t;
	assign span_abs   = span_abs11[SPAN_W-1:0];
	assign span_ad    = ad_high_q - ad_low_q;

	// divider A: mean first, then mean*|span_t|/span_ad
	assign diva_start    = (state_q == S_READ) || (state_q == S_MUL);
	assign diva_dividend = (state_q == S_READ) ?
		{{(DIVA_N - SUM_W){1'b0}}, new_sum} :
		DIVA_N'(diva_quo[SAMPLE_BITS-1:0] * span_abs);
	assign diva_divisor  = (state_q == S_READ) ?
		{{(LEVEL_W - CNT_W){1'b0}}, cnt_next} : span_ad;

	// divider B: ad_low*|span_t|/span_ad, alongside the mean
	assign divb_start    = (state_q == S_READ);
	assign divb_dividend = DIVB_N'(ad_low_q * span_abs);

	sal_sdiv #(
		.N (DIVA_N),
		.D (LEVEL_W)
	) u_diva (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (diva_start),
		.dividend (diva_dividend),
		.divisor  (diva_divisor),
		.stat     (diva_stat),
		.quotient (diva_quo)
	);

	sal_sdiv #(
		.N (DIVB_N),
		.D (LEVEL_W)
	) u_divb (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (divb_start),
		.dividend (divb_dividend),
		.divisor  (span_ad),
		.stat     (divb_stat),
		.quotient (divb_quo)
	);

	// truncation toward zero: divide magnitudes, then apply sign
	assign mag1  = T_W'(diva_quo);
	assign mag2  = T_W'(divb_quo);
	assign term1 = span_neg ? -signed'(mag1) : signed'(mag1);
	assign term2 = span_neg ? signed'(mag2) : -signed'(mag2);
	assign t_lin = term1 + term2 + T_W'(temp_low_q);

	always_comb begin
		if (t_lin > T_MAX) begin
			t_sat = TEMP_W'(T_MAX);
		end else if (t_lin < T_MIN) begin
			t_sat = TEMP_W'(T_MIN);
		end else begin
			t_sat = t_lin[TEMP_W-1:0];
		end
		if (CMP_W'(mean_q) <= CMP_W'(ad_low_q)) begin
			t_final = TEMP_W'(temp_low_q);
		end else if (CMP_W'(mean_q) >= CMP_W'(ad_high_q)) begin
			t_final = TEMP_W'(temp_high_q);
		end else begin
			t_final = t_sat;
		end
	end

	assign out_free = !result_valid_q || result_ready;
	assign fin_go   = (state_q == S_FIN) && out_free && !divb_stat.busy;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			wptr_q         <= '0;
			warm_q         <= 1'b1;
			sum_q          <= '0;
			cnt_q          <= '0;
			sample_q       <= '0;
			mean_q         <= '0;
			result_valid_q <= 1'b0;
			average_q      <= '0;
			temp_q         <= '0;
		end else begin
			if (fin_go) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sample_q <= sample;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					sum_q <= new_sum;
					cnt_q <= cnt_next;
					if (wrap) begin
						wptr_q <= '0;
						warm_q <= 1'b0;
					end else begin
						wptr_q <= wptr_q + PTR_W'(1);
					end
					state_q <= S_DIV1;
				end
				S_DIV1: begin
					if (diva_stat.last) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					mean_q  <= diva_quo[SAMPLE_BITS-1:0];
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (diva_stat.last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						average_q <= mean_q;
						temp_q    <= t_final;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid  = result_valid_q;
	assign average_level = average_q;
	assign temperature   = temp_q;

	// ---------------- assertions ----------------
	`ASSERT_IMPLIES(a_wptr_range, clk, arst_n, 1'b1, wptr_q <= PTR_W'(DEPTH - 1))
	`ASSERT_IMPLIES(a_cnt_range, clk, arst_n, state_q == S_DIV1,
		cnt_q != '0 && cnt_q <= CNT_W'(DEPTH))
	`ASSERT_IMPLIES(a_diva_owner, clk, arst_n, diva_stat.busy,
		state_q == S_DIV1 || state_q == S_DIV2)
	`ASSERT_NEXT(a_accept_read, clk, arst_n, accept, state_q == S_READ && !sample_ready)

endmodule

`default_nettype wire

// ===== hdl/sal_ram.sv =====
// ---------------------------------------------------------------------------
// sal_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sal_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 10,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/sal_sdiv.sv =====
// ---------------------------------------------------------------------------
// sal_sdiv
// Unsigned restoring divider, one quotient bit per cycle. The dividend is
// shifted out of the quotient register MSB first while quotient bits shift in.
// ---------------------------------------------------------------------------
`default_nettype none

module sal_sdiv #(
	parameter int N = 22,
	parameter int D = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [N-1:0]        dividend,
	input  wire logic [D-1:0]        divisor,
	output sal_pkg::sdiv_stat_t      stat,
	output logic      [N-1:0]        quotient
);

	import sal_pkg::*;

	localparam int CNT_W = $clog2(N + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N-1:0]     quo_q;
	logic [D-1:0]     rem_q;
	logic [D-1:0]     den_q;
	logic [D:0]       trial;
	logic [D:0]       diff;
	logic             ge;

	assign trial = {rem_q, quo_q[N-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(N);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N-2:0], ge};
			rem_q <= ge ? diff[D-1:0] : trial[D-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.last = busy_q && (cnt_q == CNT_W'(1));
	assign quotient  = quo_q;

endmodule

`default_nettype wire

// ===== tb/sal_reading_checker.sv =====
// ---------------------------------------------------------------------------
// sal_reading_checker
// Watches the sample, result and register ports of the sensor average block.
// Keeps its own ring, running sum and calibration registers, works out the
// average level and temperature for every accepted sample word and checks
// each result word against the oldest prediction.
// ---------------------------------------------------------------------------
module sal_reading_checker #(
	parameter int DEPTH = 10,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  sample_valid,
	input  wire logic                                  sample_ready,
	input  wire logic [SAMPLE_BITS-1:0]                sample,
	input  wire logic                                  result_valid,
	input  wire logic                                  result_ready,
	input  wire logic [SAMPLE_BITS-1:0]                average_level,
	input  wire logic signed [sal_pkg::TEMP_W-1:0]     temperature,
	input  wire logic                                  cfg_we,
	input  wire logic [sal_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [sal_pkg::CFG_DATA_W-1:0]        cfg_data,
	output int                                         errors,
	output int                                         outstanding,
	output int                                         checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import sal_pkg::*;

	typedef struct {
		logic [SAMPLE_BITS-1:0]   level;
		logic signed [TEMP_W-1:0] degrees;
	} reading_t;

	reading_t expected_readings[$];

	// calibration registers as the block should hold them
	logic [LEVEL_W-1:0]           ad_low_q;
	logic [LEVEL_W-1:0]           ad_high_q;
	logic signed [TEMP_CFG_W-1:0] temp_low_q;
	logic signed [TEMP_CFG_W-1:0] temp_high_q;

	logic [SAMPLE_BITS-1:0] ring [DEPTH];
	int unsigned            wr_ptr;
	bit                     warming;
	int unsigned            level_sum;

	int n_errors = 0;
	int n_checked = 0;

	function automatic logic signed [TEMP_W-1:0] level_to_degrees(
		input logic [SAMPLE_BITS-1:0] lvl
	);
		longint m, lo, hi, tl, th, span_t, span_ad, t;
		m = longint'(lvl);
		lo = longint'(ad_low_q);
		hi = longint'(ad_high_q);
		tl = longint'(temp_low_q);
		th = longint'(temp_high_q);
		// low clamp is tested first, so inverted levels fall through to temp_high
		if (m <= lo)
			t = tl;
		else if (m >= hi)
			t = th;
		else begin
			span_t = th - tl;
			span_ad = hi - lo;
			t = (m * span_t) / span_ad + (-lo * span_t) / span_ad + tl;
			if (t > TEMP_MAX)
				t = TEMP_MAX;
			if (t < TEMP_MIN)
				t = TEMP_MIN;
		end
		return t[TEMP_W-1:0];
	endfunction

	function automatic reading_t take_sample(input logic [SAMPLE_BITS-1:0] s);
		reading_t    r;
		int unsigned p, divisor, mean;
		p = wr_ptr;
		// an entry leaves the sum only once the ring has wrapped
		if (!warming)
			level_sum -= ring[p];
		ring[p] = s;
		level_sum += s;
		if (p == DEPTH - 1) begin
			warming = 1'b0;
			wr_ptr = 0;
		end else begin
			wr_ptr = p + 1;
		end
		divisor = warming ? wr_ptr : DEPTH;
		mean = level_sum / divisor;
		r.level = mean[SAMPLE_BITS-1:0];
		r.degrees = level_to_degrees(r.level);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			ad_low_q = AD_LOW_RST;
			ad_high_q = AD_HIGH_RST;
			temp_low_q = TEMP_LOW_RST;
			temp_high_q = TEMP_HIGH_RST;
			wr_ptr = 0;
			warming = 1'b1;
			level_sum = 0;
			expected_readings.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_AD_LOW:    ad_low_q = cfg_data[LEVEL_W-1:0];
					REG_AD_HIGH:   ad_high_q = cfg_data[LEVEL_W-1:0];
					REG_TEMP_LOW:  temp_low_q = cfg_data[TEMP_CFG_W-1:0];
					REG_TEMP_HIGH: temp_high_q = cfg_data[TEMP_CFG_W-1:0];
					default: ;  // unmapped index, no effect
				endcase
			end
			if (result_valid && result_ready) begin
				if (expected_readings.size() == 0) begin
					$error("result word with no sample outstanding: average_level %0d, temperature %0d",
						average_level, temperature);
					n_errors++;
				end else begin
					want = expected_readings.pop_front();
					if (average_level !== want.level) begin
						$error("average_level: expected %0d, got %0d", want.level, average_level);
						n_errors++;
					end
					if (temperature !== want.degrees) begin
						$error("temperature: expected %0d, got %0d", want.degrees, temperature);
						n_errors++;
					end
					n_checked++;
				end
			end
			if (sample_valid && sample_ready)
				expected_readings.push_back(take_sample(sample));
		end
		errors <= n_errors;
		outstanding <= expected_readings.size();
		checked <= n_checked;
	end

endmodule

// ===== tb/tb_sensor_average_linear_calibrate.sv =====
// ---------------------------------------------------------------------------
// tb_sensor_average_linear_calibrate
// Drives converter samples through the moving average and calibration block
// under a series of calibration settings (reset values, full scale, falling,
// inverted, equal and two-count spans, random) with bursty sample traffic and
// a stalling result side. A checker beside the block predicts every reading.
// ---------------------------------------------------------------------------
module tb_sensor_average_linear_calibrate;
	timeunit 1ns;
	timeprecision 1ps;

	import sal_pkg::*;

	localparam int DEPTH = 10;
	localparam int SAMPLE_BITS = 12;
	localparam int LEVEL_MAX = (1 << SAMPLE_BITS) - 1;
	localparam int N_CAL = 10;           // calibration settings, first is reset
	localparam int WORDS_PER_CAL = 180;
	localparam int RUN_LEN = 12;         // longer than the ring, so runs settle
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef enum {DRAIN_FREE, DRAIN_CHOPPY, DRAIN_SLUGGISH} drain_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     sample_valid = 1'b0;
	logic                     sample_ready;
	logic [SAMPLE_BITS-1:0]   sample = '0;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	logic [SAMPLE_BITS-1:0]   average_level;
	logic signed [TEMP_W-1:0] temperature;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	int errors;
	int outstanding;
	int checked;

	int words_sent = 0;
	int burst_left = 0;
	int cycles = 0;
	int cur_ad_low = int'(AD_LOW_RST);
	int cur_ad_high = int'(AD_HIGH_RST);

	sensor_average_linear_calibrate #(
		.DEPTH(DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (.*);

	sal_reading_checker #(
		.DEPTH(DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) readings_chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_sensor_average_linear_calibrate: FAIL");
			$finish;
		end
	end

	function automatic int clamp_level(input int lvl);
		if (lvl < 0)
			return 0;
		if (lvl > LEVEL_MAX)
			return LEVEL_MAX;
		return lvl;
	endfunction

	// level for a run of equal samples; some lie near the clamps so the mean lands on them
	function automatic int pick_target();
		case ($urandom_range(0, 4))
			0: return clamp_level(cur_ad_low + int'($urandom_range(0, 2)) - 1);
			1: return clamp_level(cur_ad_high + int'($urandom_range(0, 2)) - 1);
			2: return (cur_ad_low + cur_ad_high) / 2;
			3: return $urandom_range(0, 1) ? LEVEL_MAX : 0;
			default: return $urandom_range(0, LEVEL_MAX);
		endcase
	endfunction

	// offer one word and hold it until taken; bursts may end in a random gap
	task automatic send_word(input logic [SAMPLE_BITS-1:0] v);
		int gap;
		sample_valid <= 1'b1;
		sample <= v;
		do
			@(posedge clk);
		while (!sample_ready);
		words_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic apply_calibration(input int al, input int ah, input int tl, input int th);
		logic [CFG_DATA_W-1:0] word;
		write_reg(REG_AD_LOW, CFG_DATA_W'(al));
		write_reg(REG_AD_HIGH, CFG_DATA_W'(ah));
		// junk in the bits above the temperature field must be dropped
		word = CFG_DATA_W'($urandom);
		word[TEMP_CFG_W-1:0] = tl[TEMP_CFG_W-1:0];
		write_reg(REG_TEMP_LOW, word);
		word = CFG_DATA_W'($urandom);
		word[TEMP_CFG_W-1:0] = th[TEMP_CFG_W-1:0];
		write_reg(REG_TEMP_HIGH, word);
		write_reg(CFG_IDX_W'($urandom_range(REG_TEMP_HIGH + 1, (1 << CFG_IDX_W) - 1)),
			CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_ad_low = al;
		cur_ad_high = ah;
	endtask

	// result side: its own stall pattern, plus two long hold-offs
	initial begin
		drain_mode_t mode;
		int mode_left, taken, hold_at;
		mode = DRAIN_FREE;
		mode_left = 0;
		taken = 0;
		hold_at = 300;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				taken++;
			if (taken >= hold_at) begin
				hold_at += 900;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = drain_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 400);
				end
				mode_left--;
				case (mode)
					DRAIN_FREE:   result_ready <= 1'b1;
					DRAIN_CHOPPY: result_ready <= 1'($urandom_range(0, 1));
					default:      result_ready <= ($urandom_range(0, 39) == 0);
				endcase
			end
		end
	end

	initial begin
		int opening[$];
		int al, ah, tl, th, target, kind, v;
		bit run;
		opening = '{0, LEVEL_MAX, 1061, 1062, 2048, 2049, 2050, 1060, 'h555, 'hAAA,
			LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX,
			LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX,
			0, 0, 0, 1, LEVEL_MAX - 1};
		target = 0;
		run = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first pass divisors, wrap, full-scale sum, both clamps at reset values
		foreach (opening[i])
			send_word(SAMPLE_BITS'(opening[i]));

		for (int cal = 0; cal < N_CAL; cal++) begin
			if (cal > 0) begin
				wait_idle();
				case (cal)
					1: begin al = 0;    ah = LEVEL_MAX; tl = -512; th = 511;  end
					2: begin al = 3000; ah = 1000;      tl = 200;  th = -300; end
					3: begin al = 2048; ah = 2048;      tl = -100; th = 100;  end
					4: begin al = LEVEL_MAX; ah = 0;    tl = 511;  th = -512; end
					5: begin al = 2000; ah = 2002;      tl = -512; th = 511;  end
					6: begin al = 0;    ah = LEVEL_MAX; tl = 511;  th = -512; end
					default: begin
						al = $urandom_range(0, LEVEL_MAX);
						ah = ($urandom_range(0, 3) == 0) ? $urandom_range(0, LEVEL_MAX)
							: $urandom_range(al, LEVEL_MAX);
						tl = int'($urandom_range(0, (1 << TEMP_CFG_W) - 1)) - (1 << (TEMP_CFG_W - 1));
						th = int'($urandom_range(0, (1 << TEMP_CFG_W) - 1)) - (1 << (TEMP_CFG_W - 1));
					end
				endcase
				apply_calibration(al, ah, tl, th);
			end
			for (int i = 0; i < WORDS_PER_CAL; i++) begin
				if (i % RUN_LEN == 0) begin
					target = pick_target();
					run = ($urandom_range(0, 2) == 0);
				end
				kind = $urandom_range(0, 99);
				if (run || (kind >= 45 && kind < 70))
					v = target;
				else if (kind < 45)
					v = $urandom_range(0, LEVEL_MAX);
				else if (kind < 85)
					v = $urandom_range(0, 1) ? LEVEL_MAX : 0;
				else
					v = clamp_level(target + int'($urandom_range(0, 8)) - 4);
				send_word(SAMPLE_BITS'(v));
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d sample words sent, %0d readings checked over %0d calibration settings",
			words_sent, checked, N_CAL);
		$display("settings: reset, full scale rising and falling, inverted, equal, two-count span, random");
		if (errors == 0)
			$display("tb_sensor_average_linear_calibrate: PASS");
		else
			$display("tb_sensor_average_linear_calibrate: FAIL");
		$finish;
	end

endmodule
